### src/ssm_pkg.sv
// Package for the speculation slot manager: sizes, codes, command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package ssm_pkg;
   localparam int SLOTS = 8;
   localparam int CPUS = 4;
   localparam int BUF_BYTES = 4096;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CPU_W = (CPUS > 1) ? $clog2(CPUS) : 1;
   localparam int FILL_DEPTH = SLOTS * CPUS;
   localparam int FILL_AW = $clog2(FILL_DEPTH);
   localparam int LEN_W = 13;

   typedef enum logic [2:0] {
      ST_INACTIVE = 3'd0, ST_ACTIVE = 3'd1, ST_ACTIVEONE = 3'd2,
      ST_ACTIVEMANY = 3'd3, ST_COMMITTING = 3'd4, ST_COMMITTINGMANY = 3'd5,
      ST_DISCARDING = 3'd6, ST_UNUSED = 3'd7
   } slot_st_type;

   typedef enum logic [2:0] {
      K_ALLOC = 3'd0, K_SPEC = 3'd1, K_RECORD = 3'd2, K_COMMIT = 3'd3,
      K_DISCARD = 3'd4, K_CLEAN = 3'd5, K_RSV6 = 3'd6, K_RSV7 = 3'd7
   } kind_type;

   localparam logic [1:0] RS_OK = 2'd0;
   localparam logic [1:0] RS_NOEFF = 2'd1;
   localparam logic [1:0] RS_ILLEGAL = 2'd2;
   localparam logic [1:0] RS_NOFREE = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot_id_out;
      logic [1:0] cpu_out;
      logic granted;
      logic is_transfer;
      logic [12:0] transfer_bytes;
      logic last;
      logic [31:0] busy_failures;
      logic [31:0] unavailable_failures;
   } rsp_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] slot_id;
      logic [1:0] cpu;
      logic [12:0] length;
   } req_type;
endpackage

### src/ssm_if.sv
// Valid/ready channel interfaces for requests and results.
// No dependencies.
`timescale 1ns / 1ps
interface ssm_req_if;
   logic valid;
   logic ready;
   logic [2:0] kind;
   logic [3:0] slot_id;
   logic [1:0] cpu;
   logic [12:0] length;
   modport source (output valid, kind, slot_id, cpu, length, input ready);
   modport sink (input valid, kind, slot_id, cpu, length, output ready);
endinterface

interface ssm_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [3:0] slot_id_out;
   logic [1:0] cpu_out;
   logic granted;
   logic is_transfer;
   logic [12:0] transfer_bytes;
   logic last;
   logic [31:0] busy_failures;
   logic [31:0] unavailable_failures;
   modport source (output valid, status, slot_id_out, cpu_out, granted, is_transfer,
      transfer_bytes, last, busy_failures, unavailable_failures, input ready);
   modport sink (input valid, status, slot_id_out, cpu_out, granted, is_transfer,
      transfer_bytes, last, busy_failures, unavailable_failures, output ready);
endinterface

### src/ssm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ssm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

### src/ssm_datapath.sv
// Datapath: slot state table, fill-level RAM with per-entry valid bits, counters.
// Depends on ssm_pkg and ssm_ram.
`timescale 1ns / 1ps
module ssm_datapath (
   input  logic clock,
   input  logic reset,
   input  logic                     st_we,
   input  logic [ssm_pkg::SLOT_W-1:0] st_idx,
   input  ssm_pkg::slot_st_type      st_wdata,
   input  logic                     mark_set,
   input  logic                     mark_sweep,
   input  logic                     fill_we,
   input  logic [ssm_pkg::FILL_AW-1:0] fill_addr,
   input  logic [12:0]              fill_wdata,
   input  logic                     busy_inc,
   input  logic                     unav_inc,
   output ssm_pkg::slot_st_type      st_rdata,
   output logic [12:0]              fill_rdata,
   output logic [31:0]              busy_ff,
   output logic [31:0]              unav_ff
);
   ssm_pkg::slot_st_type st_ff [ssm_pkg::SLOTS];
   logic [ssm_pkg::SLOTS-1:0] mark_ff;
   logic [ssm_pkg::FILL_DEPTH-1:0] fvalid_ff;
   logic fvalid_rd_ff;
   logic [12:0] ram_q;

   assign st_rdata = st_ff[st_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssm_pkg::SLOTS; i++) st_ff[i] <= ssm_pkg::ST_INACTIVE;
         mark_ff <= '0;
         fvalid_ff <= '0;
         busy_ff <= '0;
         unav_ff <= '0;
         fvalid_rd_ff <= 1'b0;
      end else begin
         if (mark_sweep) begin
            for (int i = 0; i < ssm_pkg::SLOTS; i++)
               if (mark_ff[i]) st_ff[i] <= ssm_pkg::ST_INACTIVE;
            mark_ff <= '0;
         end else begin
            if (st_we) st_ff[st_idx] <= st_wdata;
            if (mark_set) mark_ff[st_idx] <= 1'b1;
         end
         if (fill_we) fvalid_ff[fill_addr] <= 1'b1;
         fvalid_rd_ff <= fvalid_ff[fill_addr];
         if (busy_inc) busy_ff <= busy_ff + 32'd1;
         if (unav_inc) unav_ff <= unav_ff + 32'd1;
      end
   end

   ssm_ram #(.WIDTH(13), .DEPTH(ssm_pkg::FILL_DEPTH)) u_fill (
      .clock(clock), .we(fill_we), .addr(fill_addr), .wdata(fill_wdata), .rdata(ram_q));

   assign fill_rdata = fvalid_rd_ff ? ram_q : 13'd0;
endmodule

### src/ssm_ctrl.sv
// Controller: sequences each request over the slot table and fill RAM.
// Depends on ssm_pkg.
`timescale 1ns / 1ps
module ssm_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic [3:0] slots_in_use,
   input  logic req_valid,
   output logic req_ready,
   input  ssm_pkg::req_type req,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ssm_pkg::rsp_type rsp,
   output logic st_we,
   output logic [ssm_pkg::SLOT_W-1:0] st_idx,
   output ssm_pkg::slot_st_type st_wdata,
   output logic mark_set,
   output logic mark_sweep,
   output logic fill_we,
   output logic [ssm_pkg::FILL_AW-1:0] fill_addr,
   output logic [12:0] fill_wdata,
   output logic busy_inc,
   output logic unav_inc,
   input  ssm_pkg::slot_st_type st_rdata,
   input  logic [12:0] fill_rdata,
   input  logic [31:0] busy_cnt,
   input  logic [31:0] unav_cnt
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001, S_DISP = 7'b0000010, S_SCAN = 7'b0000100,
      S_RD    = 7'b0001000, S_EXEC = 7'b0010000, S_CLN  = 7'b0100000,
      S_OUT   = 7'b1000000
   } fsm_type;

   fsm_type state_ff, state_in;
   ssm_pkg::req_type q_ff;
   logic [4:0] n_w;
   logic [4:0] sc_ff, sc_in;       // slot scan index, can reach SLOTS
   logic [3:0] cc_ff, cc_in;       // cpu scan index
   logic       cph_ff, cph_in;     // clean phase: 0 mark, 1 drain
   logic       sub_ff, sub_in;     // drain step: 0 read issue, 1 data
   logic       flag_ff, flag_in;   // busy seen / work seen
   logic       outfin_ff, outfin_in; // result ends the request
   ssm_pkg::rsp_type r_ff, r_in;
   logic [ssm_pkg::SLOT_W-1:0] sidx;
   logic [13:0] sum;

   assign n_w = (slots_in_use > 4'(ssm_pkg::SLOTS)) ? 5'(ssm_pkg::SLOTS) : {1'b0, slots_in_use};
   assign sidx = q_ff.slot_id[ssm_pkg::SLOT_W-1:0] - ssm_pkg::SLOT_W'(1);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp = '{status: r_ff.status, slot_id_out: r_ff.slot_id_out, cpu_out: r_ff.cpu_out,
      granted: r_ff.granted, is_transfer: r_ff.is_transfer,
      transfer_bytes: r_ff.transfer_bytes, last: r_ff.last,
      busy_failures: busy_cnt, unavailable_failures: unav_cnt};
   assign sum = {1'b0, fill_rdata} + {1'b0, q_ff.length};

   always_comb begin
      state_in = state_ff; sc_in = sc_ff; cc_in = cc_ff; cph_in = cph_ff;
      sub_in = sub_ff; flag_in = flag_ff; outfin_in = outfin_ff; r_in = r_ff;
      st_we = 1'b0; st_idx = sidx; st_wdata = ssm_pkg::ST_INACTIVE;
      mark_set = 1'b0; mark_sweep = 1'b0;
      fill_we = 1'b0; fill_wdata = 13'd0;
      fill_addr = ssm_pkg::FILL_AW'({sidx, q_ff.cpu[ssm_pkg::CPU_W-1:0]});
      busy_inc = 1'b0; unav_inc = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_DISP;
         S_DISP: begin
            r_in = '0; r_in.last = 1'b1; outfin_in = 1'b1;
            sc_in = '0; cc_in = '0; cph_in = 1'b0; sub_in = 1'b0; flag_in = 1'b0;
            case (q_ff.kind)
               ssm_pkg::K_ALLOC: state_in = S_SCAN;
               ssm_pkg::K_CLEAN: state_in = S_CLN;
               ssm_pkg::K_SPEC, ssm_pkg::K_RECORD, ssm_pkg::K_COMMIT,
               ssm_pkg::K_DISCARD: begin
                  if (q_ff.slot_id == 4'd0) begin
                     r_in.status = ssm_pkg::RS_NOEFF; state_in = S_OUT;
                  end else if ({1'b0, q_ff.slot_id} > n_w) begin
                     r_in.status = ssm_pkg::RS_ILLEGAL; state_in = S_OUT;
                  end else state_in = S_RD;
               end
               default: begin r_in.status = ssm_pkg::RS_NOEFF; state_in = S_OUT; end
            endcase
         end
         S_SCAN: begin
            st_idx = sc_ff[ssm_pkg::SLOT_W-1:0];
            if (sc_ff >= n_w) begin
               r_in.status = ssm_pkg::RS_NOFREE;
               busy_inc = flag_ff; unav_inc = !flag_ff; state_in = S_OUT;
            end else if (st_rdata == ssm_pkg::ST_INACTIVE) begin
               st_we = 1'b1; st_wdata = ssm_pkg::ST_ACTIVE;
               r_in.slot_id_out = 4'(sc_ff + 5'd1); state_in = S_OUT;
            end else begin
               if (st_rdata == ssm_pkg::ST_COMMITTING || st_rdata == ssm_pkg::ST_COMMITTINGMANY
                   || st_rdata == ssm_pkg::ST_DISCARDING) flag_in = 1'b1;
               sc_in = sc_ff + 5'd1;
            end
         end
         S_RD: state_in = S_EXEC; // fill RAM read in flight
         S_EXEC: begin
            state_in = S_OUT;
            r_in.status = ssm_pkg::RS_NOEFF;
            case (q_ff.kind)
               ssm_pkg::K_SPEC: begin
                  if (st_rdata == ssm_pkg::ST_ACTIVE || st_rdata == ssm_pkg::ST_ACTIVEONE ||
                      st_rdata == ssm_pkg::ST_ACTIVEMANY) begin
                     r_in.status = ssm_pkg::RS_OK; r_in.granted = 1'b1;
                  end
                  if (st_rdata == ssm_pkg::ST_ACTIVE) begin
                     st_we = 1'b1; st_wdata = ssm_pkg::ST_ACTIVEONE;
                  end else if (st_rdata == ssm_pkg::ST_ACTIVEONE && fill_rdata == 13'd0) begin
                     st_we = 1'b1; st_wdata = ssm_pkg::ST_ACTIVEMANY;
                  end
               end
               ssm_pkg::K_RECORD: begin
                  if (st_rdata == ssm_pkg::ST_ACTIVEONE || st_rdata == ssm_pkg::ST_ACTIVEMANY) begin
                     r_in.status = ssm_pkg::RS_OK; fill_we = 1'b1;
                     fill_wdata = (sum > 14'(ssm_pkg::BUF_BYTES)) ?
                        13'(ssm_pkg::BUF_BYTES) : sum[12:0];
                  end
               end
               ssm_pkg::K_COMMIT: begin
                  if (st_rdata == ssm_pkg::ST_ACTIVE || st_rdata == ssm_pkg::ST_ACTIVEONE ||
                      st_rdata == ssm_pkg::ST_ACTIVEMANY ||
                      st_rdata == ssm_pkg::ST_COMMITTINGMANY) begin
                     r_in.status = ssm_pkg::RS_OK; r_in.is_transfer = 1'b1;
                     r_in.slot_id_out = q_ff.slot_id; r_in.cpu_out = q_ff.cpu;
                     r_in.transfer_bytes = fill_rdata;
                     fill_we = 1'b1; st_we = 1'b1;
                     if (st_rdata == ssm_pkg::ST_ACTIVEMANY ||
                         st_rdata == ssm_pkg::ST_COMMITTINGMANY ||
                         (st_rdata == ssm_pkg::ST_ACTIVEONE && fill_rdata == 13'd0))
                        st_wdata = ssm_pkg::ST_COMMITTINGMANY;
                     else st_wdata = ssm_pkg::ST_INACTIVE;
                  end
               end
               default: begin // discard
                  if (st_rdata == ssm_pkg::ST_ACTIVE || st_rdata == ssm_pkg::ST_ACTIVEMANY ||
                      st_rdata == ssm_pkg::ST_ACTIVEONE) begin
                     r_in.status = ssm_pkg::RS_OK; fill_we = 1'b1; st_we = 1'b1;
                     st_wdata = (st_rdata == ssm_pkg::ST_ACTIVEONE && fill_rdata != 13'd0) ?
                        ssm_pkg::ST_INACTIVE : ssm_pkg::ST_DISCARDING;
                  end
               end
            endcase
         end
         S_CLN: begin
            st_idx = sc_ff[ssm_pkg::SLOT_W-1:0];
            fill_addr = ssm_pkg::FILL_AW'({sc_ff[ssm_pkg::SLOT_W-1:0],
                                           cc_ff[ssm_pkg::CPU_W-1:0]});
            if (!cph_ff) begin
               // mark pass over enabled slots
               if (sc_ff >= n_w) begin
                  sc_in = '0;
                  if (!flag_ff) begin
                     r_in.status = ssm_pkg::RS_NOEFF; state_in = S_OUT;
                  end else cph_in = 1'b1;
               end else begin
                  if (st_rdata == ssm_pkg::ST_DISCARDING ||
                      st_rdata == ssm_pkg::ST_COMMITTINGMANY) begin
                     mark_set = 1'b1; flag_in = 1'b1;
                  end
                  sc_in = sc_ff + 5'd1;
               end
            end else if (cc_ff >= 4'(ssm_pkg::CPUS)) begin
               mark_sweep = 1'b1;
               r_in = '0; r_in.last = 1'b1; outfin_in = 1'b1; state_in = S_OUT;
            end else if (sc_ff >= n_w) begin
               sc_in = '0; cc_in = cc_ff + 4'd1;
            end else if (!sub_ff) begin
               sub_in = 1'b1; // read issued at this address
            end else begin
               sub_in = 1'b0; sc_in = sc_ff + 5'd1;
               if (st_rdata == ssm_pkg::ST_DISCARDING) fill_we = 1'b1;
               else if (st_rdata == ssm_pkg::ST_COMMITTINGMANY && fill_rdata != 13'd0) begin
                  fill_we = 1'b1;
                  r_in = '0; r_in.is_transfer = 1'b1;
                  r_in.slot_id_out = 4'(sc_ff + 5'd1);
                  r_in.cpu_out = 2'(cc_ff);
                  r_in.transfer_bytes = fill_rdata;
                  outfin_in = 1'b0; state_in = S_OUT;
               end
            end
         end
         S_OUT: if (rsp_ready) state_in = outfin_ff ? S_IDLE : S_CLN;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == S_IDLE && req_valid) q_ff <= req;
      sc_ff <= sc_in; cc_ff <= cc_in; cph_ff <= cph_in; sub_ff <= sub_in;
      flag_ff <= flag_in; outfin_ff <= outfin_in; r_ff <= r_in;
   end
endmodule

### src/speculation_slot_manager.sv
// Top level of the speculation slot manager: channels, CSR port, controller, datapath.
// Depends on ssm_pkg, ssm_if, ssm_ctrl, ssm_datapath.
//
// Usage: requests arrive as words on req (kind, slot_id, cpu, length) and
// results leave as words on rsp, one word per result, last set on the
// final word of a request. One request is in work at a time; req_ready is
// high only while idle. Speculate, record, commit and discard pass through dispatch,
// fill RAM read, execute and result; id zero, bad ids and reserved kinds go from
// dispatch to the result; allocate scans the enabled slots in order. Clean marks
// the enabled slots and, with work, walks the single-port fill RAM cpu by cpu and
// slot by slot, a read issue then a data step per pair, with a transfer word for
// each committing pair with bytes. The sequencer returns to idle after the
// result before the next request is taken. A stalled rsp holds the result word
// and the sequencer waits. Reset clears slot states, fill valid bits, the failure
// counters, and sets slots_in_use to 8; no clearing pass is needed.
// The CSR slots_in_use sits at address 0 and is written in the APB access cycle.
`timescale 1ns / 1ps
module speculation_slot_manager (
   input  logic clock,
   input  logic reset,
   ssm_req_if.sink   req,
   ssm_rsp_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [3:0] siu_ff;
   ssm_pkg::req_type req_w;
   ssm_pkg::rsp_type rsp_w;
   logic st_we, mark_set, mark_sweep, fill_we, busy_inc, unav_inc;
   logic [ssm_pkg::SLOT_W-1:0] st_idx;
   ssm_pkg::slot_st_type st_wdata, st_rdata;
   logic [ssm_pkg::FILL_AW-1:0] fill_addr;
   logic [12:0] fill_wdata, fill_rdata;
   logic [31:0] busy_cnt, unav_cnt;

   // CSR: single register, write in the access phase
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 1'b0) ? {28'd0, siu_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) siu_ff <= 4'd8;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0)
         siu_ff <= csr_pwdata[3:0];
   end

   assign req_w = '{kind: req.kind, slot_id: req.slot_id, cpu: req.cpu, length: req.length};

   ssm_ctrl u_ctrl (
      .clock, .reset, .slots_in_use(siu_ff),
      .req_valid(req.valid), .req_ready(req.ready), .req(req_w),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp_w),
      .st_we, .st_idx, .st_wdata, .mark_set, .mark_sweep, .fill_we, .fill_addr,
      .fill_wdata, .busy_inc, .unav_inc, .st_rdata, .fill_rdata, .busy_cnt, .unav_cnt);

   ssm_datapath u_dp (
      .clock, .reset, .st_we, .st_idx, .st_wdata, .mark_set,
      .mark_sweep, .fill_we, .fill_addr, .fill_wdata, .busy_inc, .unav_inc, .st_rdata,
      .fill_rdata, .busy_ff(busy_cnt), .unav_ff(unav_cnt));

   // drive result word
   assign rsp.status = rsp_w.status;
   assign rsp.slot_id_out = rsp_w.slot_id_out;
   assign rsp.cpu_out = rsp_w.cpu_out;
   assign rsp.granted = rsp_w.granted;
   assign rsp.is_transfer = rsp_w.is_transfer;
   assign rsp.transfer_bytes = rsp_w.transfer_bytes;
   assign rsp.last = rsp_w.last;
   assign rsp.busy_failures = rsp_w.busy_failures;
   assign rsp.unavailable_failures = rsp_w.unavailable_failures;

`ifndef SYNTH
   // never accept a request while a result word is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request accepted during result");
   // counters move by at most one per cycle
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !(busy_inc && unav_inc)) else $error("both failure counters bumped");
   // a transfer word always names its slot
   a_xfer_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.is_transfer) |-> (rsp.slot_id_out != 4'd0))
      else $error("transfer without slot");
`endif
endmodule

### test/ssm_checker.sv
// Checker for the speculation slot manager: watches the request, result and CSR ports,
// predicts every result word and compares it field by field. Depends on ssm_pkg, ssm_if.
`timescale 1ns / 1ps
module ssm_checker
   import ssm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ssm_req_if          req,
   ssm_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          words_pending
);
   slot_st_type      slot_st[SLOTS];
   logic [12:0]      fill[FILL_DEPTH];
   logic [3:0]       slots_cfg;
   logic [31:0]      busy_cnt;
   logic [31:0]      unavail_cnt;
   rsp_type          exp_words[$];

   assign words_pending = exp_words.size();

   function automatic int enabled();
      return (slots_cfg < SLOTS) ? int'(slots_cfg) : SLOTS;
   endfunction

   task automatic push_word(logic [1:0] st, logic [3:0] sl, logic [1:0] c, logic g,
                            logic x, logic [12:0] b, logic l);
      rsp_type w;
      w.status = st;
      w.slot_id_out = sl;
      w.cpu_out = c;
      w.granted = g;
      w.is_transfer = x;
      w.transfer_bytes = b;
      w.last = l;
      w.busy_failures = busy_cnt;
      w.unavailable_failures = unavail_cnt;
      exp_words.push_back(w);
   endtask

   // Move slot s on cpu c toward committed; ok when its state allows a commit.
   task automatic commit_slot(int s, int c, output bit ok, output logic [12:0] b);
      slot_st_type cur;
      slot_st_type nxt;
      cur = slot_st[s];
      nxt = cur;
      ok = 1'b1;
      b = '0;
      case (cur)
         ST_ACTIVE: nxt = ST_COMMITTING;
         ST_ACTIVEONE: nxt = (fill[s*CPUS+c] != 0) ? ST_COMMITTING : ST_COMMITTINGMANY;
         ST_ACTIVEMANY: nxt = ST_COMMITTINGMANY;
         ST_COMMITTINGMANY: nxt = cur;
         default: ok = 1'b0;
      endcase
      if (ok) begin
         b = fill[s*CPUS+c];
         if (nxt == ST_COMMITTING) nxt = ST_INACTIVE;
         slot_st[s] = nxt;
         fill[s*CPUS+c] = '0;
      end
   endtask

   task automatic predict(kind_type k, logic [3:0] id, logic [1:0] cpu_in, logic [12:0] len);
      int n;
      int s;
      int c;
      bit busy;
      bit work;
      bit ok;
      bit g;
      bit mark[SLOTS];
      logic [12:0] b;
      logic [13:0] sum;
      slot_st_type st;
      n = enabled();
      c = int'(cpu_in) % CPUS;
      if (k == K_ALLOC) begin
         busy = 1'b0;
         for (s = 0; s < n; s++) begin
            if (slot_st[s] == ST_INACTIVE) begin
               slot_st[s] = ST_ACTIVE;
               push_word(RS_OK, 4'(s + 1), 2'd0, 1'b0, 1'b0, '0, 1'b1);
               return;
            end
            if (slot_st[s] inside {ST_COMMITTING, ST_COMMITTINGMANY, ST_DISCARDING})
               busy = 1'b1;
         end
         if (busy) busy_cnt++;
         else unavail_cnt++;
         push_word(RS_NOFREE, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
         return;
      end
      if (k == K_CLEAN) begin
         work = 1'b0;
         for (s = 0; s < SLOTS; s++) mark[s] = 1'b0;
         for (s = 0; s < n; s++)
            if (slot_st[s] inside {ST_DISCARDING, ST_COMMITTINGMANY}) begin
               mark[s] = 1'b1;
               work = 1'b1;
            end
         if (!work) begin
            push_word(RS_NOEFF, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
            return;
         end
         // Drain cpu by cpu, slots ascending within each cpu.
         for (int cc = 0; cc < CPUS; cc++)
            for (s = 0; s < n; s++) begin
               if (slot_st[s] == ST_DISCARDING) begin
                  fill[s*CPUS+cc] = '0;
               end else if (slot_st[s] == ST_COMMITTINGMANY && fill[s*CPUS+cc] != 0) begin
                  commit_slot(s, cc, ok, b);
                  if (ok) push_word(RS_OK, 4'(s + 1), 2'(cc), 1'b0, 1'b1, b, 1'b0);
               end
            end
         for (s = 0; s < SLOTS; s++)
            if (mark[s]) slot_st[s] = ST_INACTIVE;
         push_word(RS_OK, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
         return;
      end
      if (k == K_RSV6 || k == K_RSV7 || id == 0) begin
         push_word(RS_NOEFF, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
         return;
      end
      if (int'(id) > n) begin
         push_word(RS_ILLEGAL, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
         return;
      end
      s = int'(id) - 1;
      st = slot_st[s];
      case (k)
         K_SPEC: begin
            g = 1'b0;
            if (st == ST_ACTIVE) begin
               slot_st[s] = ST_ACTIVEONE;
               g = 1'b1;
            end else if (st == ST_ACTIVEONE) begin
               if (fill[s*CPUS+c] == 0) slot_st[s] = ST_ACTIVEMANY;
               g = 1'b1;
            end else if (st == ST_ACTIVEMANY) begin
               g = 1'b1;
            end
            push_word(g ? RS_OK : RS_NOEFF, 4'd0, 2'd0, g, 1'b0, '0, 1'b1);
         end
         K_RECORD: begin
            if (st == ST_ACTIVEONE || st == ST_ACTIVEMANY) begin
               sum = {1'b0, fill[s*CPUS+c]} + {1'b0, len};
               fill[s*CPUS+c] = (sum > BUF_BYTES) ? 13'(BUF_BYTES) : sum[12:0];
               push_word(RS_OK, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
            end else begin
               push_word(RS_NOEFF, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
            end
         end
         K_COMMIT: begin
            commit_slot(s, c, ok, b);
            if (ok) push_word(RS_OK, id, 2'(c), 1'b0, 1'b1, b, 1'b1);
            else push_word(RS_NOEFF, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
         end
         default: begin
            if (st == ST_ACTIVE || st == ST_ACTIVEMANY) begin
               slot_st[s] = ST_DISCARDING;
            end else if (st == ST_ACTIVEONE) begin
               slot_st[s] = (fill[s*CPUS+c] != 0) ? ST_INACTIVE : ST_DISCARDING;
            end else begin
               push_word(RS_NOEFF, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
               return;
            end
            fill[s*CPUS+c] = '0;
            push_word(RS_OK, 4'd0, 2'd0, 1'b0, 1'b0, '0, 1'b1);
         end
      endcase
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         foreach (slot_st[i]) slot_st[i] = ST_INACTIVE;
         foreach (fill[i]) fill[i] = '0;
         slots_cfg = 4'd8;
         busy_cnt = '0;
         unavail_cnt = '0;
         exp_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == 1'b0)
            slots_cfg = csr_pwdata[3:0];
         if (req.valid && req.ready)
            predict(kind_type'(req.kind), req.slot_id, req.cpu, req.length);
         if (rsp.valid && rsp.ready) begin
            if (exp_words.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               w = exp_words.pop_front();
               check_field("status", w.status, rsp.status);
               check_field("slot_id_out", w.slot_id_out, rsp.slot_id_out);
               check_field("cpu_out", w.cpu_out, rsp.cpu_out);
               check_field("granted", w.granted, rsp.granted);
               check_field("is_transfer", w.is_transfer, rsp.is_transfer);
               check_field("transfer_bytes", w.transfer_bytes, rsp.transfer_bytes);
               check_field("last", w.last, rsp.last);
               check_field("busy_failures", w.busy_failures, rsp.busy_failures);
               check_field("unavailable_failures", w.unavailable_failures,
                           rsp.unavailable_failures);
            end
         end
      end
   end

   initial fail_count = 0;
endmodule

### test/speculation_slot_manager_tb.sv
// Testbench top for the speculation slot manager: clock, reset, request and CSR stimulus,
// result back-pressure and the verdict. Depends on ssm_pkg, ssm_if, ssm_checker and the RTL.
`timescale 1ns / 1ps
module speculation_slot_manager_tb;
   import ssm_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [0:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          words_pending;
   int          cycle_count;
   int          sent;
   int          settings_run;
   int          cur_slots;
   bit          no_idle;

   ssm_req_if req ();
   ssm_rsp_if rsp ();

   speculation_slot_manager i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   ssm_checker i_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .words_pending(words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: stall about a quarter of the time, except in the no-idle stretch.
   initial rsp.ready = 1'b0;
   always @(posedge clock) begin
      rsp.ready <= no_idle || ($urandom_range(99) >= 26);
   end

   // Hard limit on the run, far above the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Send one request word; hold it until the handshake.
   task automatic send_word(kind_type k, logic [3:0] id, logic [1:0] c, logic [12:0] len);
      if (!no_idle && $urandom_range(99) < 26) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind <= k;
      req.slot_id <= id;
      req.cpu <= c;
      req.length <= len;
      do @(posedge clock); while (!req.ready);
      sent++;
   endtask

   // Drain, let the block settle, then write slots_in_use in setup and access cycles.
   task automatic write_slots(logic [31:0] value);
      req.valid <= 1'b0;
      @(posedge clock);
      wait (words_pending == 0);
      repeat (200) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 1'b0;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_slots = (value[3:0] < SLOTS) ? int'(value[3:0]) : SLOTS;
      settings_run++;
   endtask

   // One random word, biased toward valid ids and the request mix of a live probe.
   task automatic random_word();
      int r;
      kind_type k;
      logic [3:0] id;
      logic [12:0] len;
      r = $urandom_range(99);
      if (r < 15) k = K_ALLOC;
      else if (r < 40) k = K_SPEC;
      else if (r < 65) k = K_RECORD;
      else if (r < 80) k = K_COMMIT;
      else if (r < 88) k = K_DISCARD;
      else if (r < 96) k = K_CLEAN;
      else k = $urandom_range(1) ? K_RSV6 : K_RSV7;
      if ($urandom_range(99) < 85) id = 4'($urandom_range(1, (cur_slots > 0) ? cur_slots : 1));
      else id = 4'($urandom_range(15));
      r = $urandom_range(99);
      if (r < 70) len = 13'($urandom_range(300));
      else if (r < 80) len = 13'(BUF_BYTES);
      else if (r < 90) len = 13'($urandom_range(8191));
      else len = '0;
      send_word(k, id, 2'($urandom_range(3)), len);
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.kind = K_ALLOC;
      req.slot_id = '0;
      req.cpu = '0;
      req.length = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycle_count = 0;
      sent = 0;
      settings_run = 0;
      cur_slots = 8;
      no_idle = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_slots(32'd8);
      // Directed: lifecycle of one slot, saturation, many-cpu commit and clean.
      send_word(K_ALLOC, 4'd0, 2'd0, 13'd0);
      send_word(K_SPEC, 4'd1, 2'd0, 13'd0);
      send_word(K_RECORD, 4'd1, 2'd0, 13'd4096);
      send_word(K_RECORD, 4'd1, 2'd0, 13'd8191);
      send_word(K_SPEC, 4'd1, 2'd1, 13'd0);
      send_word(K_RECORD, 4'd1, 2'd1, 13'd77);
      send_word(K_COMMIT, 4'd1, 2'd0, 13'd0);
      send_word(K_RECORD, 4'd1, 2'd3, 13'd5);
      send_word(K_CLEAN, 4'd0, 2'd0, 13'd0);
      send_word(K_CLEAN, 4'd0, 2'd0, 13'd0);
      // Wrong states, id zero, illegal ids and reserved kinds.
      send_word(K_COMMIT, 4'd1, 2'd2, 13'd0);
      send_word(K_RECORD, 4'd1, 2'd2, 13'd9);
      send_word(K_DISCARD, 4'd1, 2'd0, 13'd0);
      send_word(K_SPEC, 4'd0, 2'd3, 13'd0);
      send_word(K_SPEC, 4'd9, 2'd0, 13'd0);
      send_word(K_COMMIT, 4'd15, 2'd1, 13'd0);
      send_word(K_RSV6, 4'd1, 2'd0, 13'd0);
      send_word(K_RSV7, 4'd2, 2'd0, 13'd0);
      // One slot: discard to busy, then a busy failure and an unavailable failure.
      write_slots(32'd1);
      send_word(K_ALLOC, 4'd0, 2'd0, 13'd0);
      send_word(K_DISCARD, 4'd1, 2'd0, 13'd0);
      send_word(K_ALLOC, 4'd0, 2'd0, 13'd0);
      send_word(K_CLEAN, 4'd0, 2'd0, 13'd0);
      send_word(K_ALLOC, 4'd0, 2'd0, 13'd0);
      send_word(K_ALLOC, 4'd0, 2'd0, 13'd0);
      send_word(K_SPEC, 4'd2, 2'd0, 13'd0);

      // Random phases across settings, zero and the field maximum among them.
      write_slots(32'd0);
      repeat (20) random_word();
      write_slots(32'd8);
      no_idle = 1'b1;
      repeat (60) random_word();
      no_idle = 1'b0;
      repeat (40) random_word();
      write_slots(32'd3);
      repeat (50) random_word();
      write_slots(32'hFFFF_FFFF);
      repeat (60) random_word();
      write_slots(32'd5);
      repeat (40) random_word();
      write_slots(32'd1);
      repeat (30) random_word();
      req.valid <= 1'b0;
      @(posedge clock);

      wait (words_pending == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d request words over %0d slot settings in %0d cycles.",
               sent, settings_run, cycle_count);
      if (fail_count == 0 && words_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
